@@ hw/rtl/itoa_pkg.sv @@
// Shared types, opcodes and character tables of the integer to ASCII formatter.
`timescale 1ns / 1ps

package itoa_pkg;

    localparam logic [1:0] OP_SDEC = 2'd0;
    localparam logic [1:0] OP_UDEC = 2'd1;
    localparam logic [1:0] OP_HEXL = 2'd2;
    localparam logic [1:0] OP_HEXU = 2'd3;

    localparam int unsigned MaxChars = 16;
    localparam int unsigned CntW     = $clog2(MaxChars + 1);
    localparam int unsigned PtrW     = $clog2(MaxChars);

    // ceil(2^35 / 10): floor(x * DivTenRecip / 2^35) == floor(x / 10) for 32-bit x
    localparam logic [31:0] DivTenRecip = 32'hCCCC_CCCD;
    localparam int unsigned DivTenShift = 35;

    localparam logic [7:0] CHAR_MINUS = 8'h2D;

    localparam logic [7:0] HEX_LOWER [16] = '{
        8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
        8'h38, 8'h39, 8'h61, 8'h62, 8'h63, 8'h64, 8'h65, 8'h66
    };
    localparam logic [7:0] HEX_UPPER [16] = '{
        8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
        8'h38, 8'h39, 8'h41, 8'h42, 8'h43, 8'h44, 8'h45, 8'h46
    };

    typedef struct packed {
        logic [1:0]  opcode;
        logic [63:0] value;
    } t_in_word;

    typedef struct packed {
        logic [7:0]      out_char;
        logic            last_char;
        logic [CntW-1:0] char_count;
    } t_out_word;

    // controller -> datapath
    typedef struct packed {
        logic load;
        logic mul;
        logic div;
        logic emit;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic q_zero;
        logic last;
    } t_status;

endpackage

@@ hw/rtl/itoa_ctrl.sv @@
// Sequencer of the formatter: load, divide-by-ten loop, character emission.
`timescale 1ns / 1ps

module itoa_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic             i_hex,
    input  itoa_pkg::t_status i_status,
    output itoa_pkg::t_cmd   o_cmd,
    output logic             o_busy
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_MUL,
        S_DIV,
        S_EMIT
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_busy;

    always_comb begin
        o_cmd      = '0;
        o_cmd.load = (r_state == S_IDLE) && i_start;
        o_cmd.mul  = (r_state == S_MUL);
        o_cmd.div  = (r_state == S_DIV);
        o_cmd.emit = (r_state == S_EMIT);
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_state = i_hex ? S_EMIT : S_MUL;
                end
            end
            S_MUL:  n_state = S_DIV;
            S_DIV:  n_state = i_status.q_zero ? S_EMIT : S_MUL;
            S_EMIT: begin
                if (i_status.last) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_busy  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_busy  <= (n_state != S_IDLE);
        end
    end

    assign o_busy = r_busy;

endmodule

@@ hw/rtl/itoa_dpath.sv @@
// Datapath of the formatter: magnitude, divide-by-ten step, digit store, output word.
`timescale 1ns / 1ps

module itoa_dpath #(
    parameter int unsigned HEX_WIDTH = 64
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  itoa_pkg::t_cmd       i_cmd,
    input  itoa_pkg::t_in_word   i_in,
    output itoa_pkg::t_status    o_status,
    output logic                 o_valid,
    output itoa_pkg::t_out_word  o_out
);

    localparam logic [63:0] HexMask =
        (HEX_WIDTH >= 64) ? {64{1'b1}} : ((64'd1 << HEX_WIDTH) - 64'd1);
    localparam int unsigned QW = 64 - itoa_pkg::DivTenShift;

    logic [31:0]                 r_mag;
    logic [63:0]                 r_prod;
    logic [3:0]                  r_digits [itoa_pkg::MaxChars];
    logic [itoa_pkg::CntW-1:0]   r_ndig;
    logic [itoa_pkg::CntW-1:0]   r_total;
    logic                        r_sign_pend;
    logic                        r_upper;
    logic                        r_valid;
    itoa_pkg::t_out_word         r_out;

    logic [31:0]                 low;
    logic                        neg;
    logic [63:0]                 hex_val;
    logic [itoa_pkg::PtrW-1:0]   hex_top;
    logic [QW-1:0]               quot;
    logic [31:0]                 quot_x10;
    logic [3:0]                  rem;
    logic [itoa_pkg::PtrW-1:0]   rd_ptr;
    logic [3:0]                  rd_digit;
    logic [7:0]                  digit_char;

    assign low     = i_in.value[31:0];
    assign neg     = (i_in.opcode == itoa_pkg::OP_SDEC) && low[31];
    assign hex_val = i_in.value & HexMask;

    // highest nonzero nibble; zero keeps one digit
    always_comb begin
        hex_top = '0;
        for (int i = 0; i < itoa_pkg::MaxChars; i++) begin
            if (hex_val[4*i +: 4] != 4'd0) begin
                hex_top = i[itoa_pkg::PtrW-1:0];
            end
        end
    end

    assign quot     = r_prod[63:itoa_pkg::DivTenShift];
    assign quot_x10 = {quot, 3'b000} + {2'b00, quot, 1'b0};
    assign rem      = 4'(r_mag - quot_x10);

    assign rd_ptr     = itoa_pkg::PtrW'(r_ndig - 1'b1);
    assign rd_digit   = r_digits[rd_ptr];
    assign digit_char = r_upper ? itoa_pkg::HEX_UPPER[rd_digit]
                                : itoa_pkg::HEX_LOWER[rd_digit];

    assign o_status.q_zero = (quot == '0);
    assign o_status.last   = !r_sign_pend && (r_ndig == itoa_pkg::CntW'(1));

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_upper <= (i_in.opcode == itoa_pkg::OP_HEXU);
            if (i_in.opcode[1]) begin
                for (int i = 0; i < itoa_pkg::MaxChars; i++) begin
                    r_digits[i] <= hex_val[4*i +: 4];
                end
                r_ndig      <= itoa_pkg::CntW'(hex_top) + 1'b1;
                r_total     <= itoa_pkg::CntW'(hex_top) + 1'b1;
                r_sign_pend <= 1'b0;
            end else begin
                r_mag       <= neg ? (~low + 32'd1) : low;
                r_ndig      <= '0;
                r_sign_pend <= neg;
            end
        end
        if (i_cmd.mul) begin
            r_prod <= 64'(r_mag) * 64'(itoa_pkg::DivTenRecip);
        end
        if (i_cmd.div) begin
            r_digits[r_ndig[itoa_pkg::PtrW-1:0]] <= rem;
            r_mag   <= 32'(quot);
            r_ndig  <= r_ndig + 1'b1;
            r_total <= r_ndig + 1'b1 + itoa_pkg::CntW'(r_sign_pend);
        end
        if (i_cmd.emit) begin
            r_out.char_count <= r_total;
            r_out.last_char  <= o_status.last;
            if (r_sign_pend) begin
                r_out.out_char <= itoa_pkg::CHAR_MINUS;
                r_sign_pend    <= 1'b0;
            end else begin
                r_out.out_char <= digit_char;
                r_ndig         <= r_ndig - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_cmd.emit;
        end
    end

    assign o_valid = r_valid;
    assign o_out   = r_out;

endmodule

@@ hw/rtl/integer_to_ascii_formatter_unit.sv @@
// Top level of the integer to ASCII formatter: controller plus datapath.
`timescale 1ns / 1ps

// Formats one integer per command as ASCII text, most significant character
// first, one character word per cycle on o_out with o_valid high for exactly
// that cycle; the receiver cannot stall, so every word must be taken when shown.
// A command is taken at a clock edge with i_start high and o_busy low.
// Opcode 0 prints value[31:0] as signed decimal (leading '-'), opcode 1 as
// unsigned decimal, opcodes 2 and 3 print value[HEX_WIDTH-1:0] in lower or
// upper case hex. No leading zeros; zero prints as one '0'. Every word carries
// last_char on the final character and the total character count.
// A hex number goes from the command straight to emission, each word registered
// into o_out; o_busy drops in the cycle the last word is shown, so the next
// command can be taken then. A decimal number of D digits first runs D passes
// of a divide-by-ten step (one 32x32 reciprocal multiply, then remainder and
// digit store), and only then are its words shown: up to 10 digits of
// conversion and up to 11 words per command.
module integer_to_ascii_formatter_unit #(
    parameter int unsigned HEX_WIDTH = 64
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  itoa_pkg::t_in_word  i_in,
    output logic                o_busy,
    output logic                o_valid,
    output itoa_pkg::t_out_word o_out
);

    itoa_pkg::t_cmd    cmd;
    itoa_pkg::t_status status;

    // sequence the load, the divide loop and the character emission
    itoa_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (i_start),
        .i_hex    (i_in.opcode[1]),
        .i_status (status),
        .o_cmd    (cmd),
        .o_busy   (o_busy)
    );

    // hold the magnitude and digits, drive the registered output word
    itoa_dpath #(
        .HEX_WIDTH (HEX_WIDTH)
    ) u_dpath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (cmd),
        .i_in     (i_in),
        .o_status (status),
        .o_valid  (o_valid),
        .o_out    (o_out)
    );

endmodule

@@ hw/rtl/itoa_chk.sv @@
// Port-level checker of the formatter and its bind to the top level.
`timescale 1ns / 1ps

module itoa_chk (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_start,
    input logic                o_busy,
    input logic                o_valid,
    input itoa_pkg::t_out_word o_out
);

    // more characters of the same number still to come: block stays busy
    a_busy_mid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_out.last_char |-> o_busy)
        else $error("busy dropped before last character");

    // characters of one number come in consecutive cycles
    a_no_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_out.last_char |=> o_valid)
        else $error("gap inside a number");

    // a fresh command never shows a word in the cycle right after it
    a_accept_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start && !o_busy |=> !o_valid)
        else $error("word shown right after accept");

    // character count is within one to sixteen
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_out.char_count != '0) && (o_out.char_count <= 5'd16))
        else $error("character count out of range");

    // last character frees the block
    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_out.last_char |-> !o_busy)
        else $error("busy after last character");

endmodule

bind integer_to_ascii_formatter_unit itoa_chk u_itoa_chk (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_start (i_start),
    .o_busy  (o_busy),
    .o_valid (o_valid),
    .o_out   (o_out)
);
